// ----- sv/bitmap_font_glyph_renderer_top_defines.svh -----
// ----------------------------------------------------------------------------
// Bitmap font glyph renderer assertion macros
// Shared assertion forms for the renderer's checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FONT_GLYPH_RENDERER_TOP_DEFINES_SVH
`define BITMAP_FONT_GLYPH_RENDERER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFGR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bfgr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BFGR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bfgr assertion failed");

`endif

// ----- sv/bfgr_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap font glyph renderer package
// Register indexes, command codes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package bfgr_pkg;

   localparam int DEF_FONT_STORE_BYTES = 8192;
   localparam int DEF_MAX_GLYPH_WIDTH = 16;
   localparam int DEF_MAX_GLYPH_HEIGHT = 32;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int ROW_NUM_W = 5;

   localparam logic [CSR_INDEX_W-1:0] REG_LINE_PITCH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GLYPH_WIDTH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GLYPH_HEIGHT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GLYPH_COUNT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_GLYPH_BYTES = 3'd4;

   localparam logic [15:0] RST_LINE_PITCH = 16'd4096;
   localparam logic [4:0] RST_GLYPH_WIDTH = 5'd8;
   localparam logic [5:0] RST_GLYPH_HEIGHT = 6'd16;
   localparam logic [9:0] RST_GLYPH_COUNT = 10'd256;
   localparam logic [6:0] RST_GLYPH_BYTES = 7'd16;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_DRAW = 2'd1;
   localparam logic [1:0] CMD_SET_CURSOR = 2'd2;

   localparam logic [7:0] CODE_CR = 8'd13;
   localparam logic [7:0] CODE_LF = 8'd10;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

`default_nettype wire

// ----- sv/bitmap_font_glyph_renderer_top.sv -----
// ----------------------------------------------------------------------------
// Bitmap font glyph renderer
// Draws fixed-size font glyphs one row per result and tracks a pixel cursor.
// ----------------------------------------------------------------------------
// Load, set cursor, carriage return and line feed complete in the idle state.
// A drawn glyph passes the setup states MUL_Y, MUL_G and ADDR on the shared
// multiplier, then makes one store read per row byte.
// The first row follows the setup states and the registered store read.
// Reset is synchronous; it zeroes the cursor and restores the register
// defaults; the glyph store keeps its contents and is not cleared.
`default_nettype none

module bitmap_font_glyph_renderer_top
   import bfgr_pkg::*;
#(
   parameter int FONT_STORE_BYTES = DEF_FONT_STORE_BYTES,
   parameter int MAX_GLYPH_WIDTH = DEF_MAX_GLYPH_WIDTH,
   parameter int MAX_GLYPH_HEIGHT = DEF_MAX_GLYPH_HEIGHT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_command,
   input  wire logic [12:0]            req_font_address,
   input  wire logic [7:0]             req_font_data,
   input  wire logic [7:0]             req_char_code,
   input  wire logic [15:0]            req_new_cursor_x,
   input  wire logic [15:0]            req_new_cursor_y,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [31:0]                 rsp_byte_offset,
   output logic [15:0]                 rsp_row_bits,
   output logic [ROW_NUM_W-1:0]        rsp_row_number,
   output logic                        rsp_last_row,
   output logic [15:0]                 rsp_cursor_x_after,
   output logic [15:0]                 rsp_cursor_y_after
);

   localparam int AW = $clog2(FONT_STORE_BYTES);
   localparam int WW = $clog2(MAX_GLYPH_WIDTH + 1);
   localparam int HW = $clog2(MAX_GLYPH_HEIGHT + 1);
   localparam int MAX_BPL = (MAX_GLYPH_WIDTH + 7) / 8;
   localparam int BW = $clog2(MAX_BPL + 1);
   localparam int KW = (MAX_BPL > 1) ? $clog2(MAX_BPL) : 1;
   localparam int JW = 8 * MAX_BPL;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_Y,
      ST_MUL_G,
      ST_ADDR,
      ST_FETCH
   } state_type;

   logic [15:0] line_pitch_ff;
   logic [4:0]  glyph_width_ff;
   logic [5:0]  glyph_height_ff;
   logic [9:0]  glyph_count_ff;
   logic [6:0]  glyph_bytes_ff;

   state_type         state_ff;
   logic [15:0]       cursor_x_ff;
   logic [15:0]       cursor_y_ff;
   logic [15:0]       x_after_ff;
   logic [9:0]        glyph_ff;
   logic [31:0]       prod_ff;
   logic [31:0]       off_ff;
   logic [AW-1:0]     addr_ff;
   logic [HW-1:0]     iss_row_ff;
   logic [KW-1:0]     iss_k_ff;
   logic [HW-1:0]     row_ff;
   logic              pend_ff;
   logic              pend_first_ff;
   logic              pend_last_ff;
   logic [JW-1:0]     joined_ff;

   logic              rsp_valid_ff;
   logic [31:0]       rsp_byte_offset_ff;
   logic [15:0]       rsp_row_bits_ff;
   logic [ROW_NUM_W-1:0] rsp_row_number_ff;
   logic              rsp_last_row_ff;
   logic [15:0]       rsp_cursor_x_after_ff;
   logic [15:0]       rsp_cursor_y_after_ff;

   logic [WW-1:0]     w_eff;
   logic [HW-1:0]     h_eff;
   logic [BW-1:0]     bpl;
   logic [2:0]        shamt;
   logic [15:0]       mul_a;
   logic [15:0]       mul_b;
   logic [31:0]       mul_p;
   logic              req_accept;
   logic              is_draw;
   logic              out_free;
   logic              row_ready;
   logic              emit_want;
   logic              emit;
   logic              hold;
   logic              issue;
   logic              last_k;
   logic              last_row;
   logic [JW-1:0]     joined_cat;
   logic [JW-1:0]     bits_cat;
   logic [7:0]        rd_data;
   store_ctl_type     store_ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pitch_ff <= RST_LINE_PITCH;
         glyph_width_ff <= RST_GLYPH_WIDTH;
         glyph_height_ff <= RST_GLYPH_HEIGHT;
         glyph_count_ff <= RST_GLYPH_COUNT;
         glyph_bytes_ff <= RST_GLYPH_BYTES;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LINE_PITCH: begin
               line_pitch_ff <= csr_data;
            end
            REG_GLYPH_WIDTH: begin
               glyph_width_ff <= csr_data[4:0];
            end
            REG_GLYPH_HEIGHT: begin
               glyph_height_ff <= csr_data[5:0];
            end
            REG_GLYPH_COUNT: begin
               glyph_count_ff <= csr_data[9:0];
            end
            REG_GLYPH_BYTES: begin
               glyph_bytes_ff <= csr_data[6:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      w_eff = (32'(glyph_width_ff) > MAX_GLYPH_WIDTH) ? WW'(MAX_GLYPH_WIDTH)
                                                       : WW'(glyph_width_ff);
      h_eff = (32'(glyph_height_ff) > MAX_GLYPH_HEIGHT) ? HW'(MAX_GLYPH_HEIGHT)
                                                         : HW'(glyph_height_ff);
      bpl = BW'((32'(w_eff) + 32'd7) >> 3);
      shamt = 3'((32'(bpl) << 3) - 32'(w_eff));

      mul_a = (state_ff == ST_MUL_G) ? {6'b0, glyph_ff} : cursor_y_ff;
      mul_b = (state_ff == ST_MUL_G) ? {9'b0, glyph_bytes_ff} : line_pitch_ff;
      mul_p = {16'b0, mul_a} * {16'b0, mul_b};

      req_accept = req_valid && !req_stall;
      is_draw = (req_command == CMD_DRAW) && (req_char_code != CODE_CR)
                && (req_char_code != CODE_LF);

      out_free = !rsp_valid_ff || !rsp_stall;
      row_ready = (bpl == '0) ? 1'b1 : (pend_ff && pend_last_ff);
      emit_want = (state_ff == ST_FETCH) && row_ready;
      emit = emit_want && out_free;
      hold = emit_want && !out_free;
      issue = (state_ff == ST_FETCH) && !hold && (bpl != '0) && (iss_row_ff < h_eff);
      last_k = (32'(iss_k_ff) + 32'd1) == 32'(bpl);
      last_row = (32'(row_ff) + 32'd1) == 32'(h_eff);

      joined_cat = pend_first_ff ? JW'(rd_data) : JW'({joined_ff, rd_data});
      bits_cat = (bpl == '0) ? '0 : (joined_cat >> shamt);

      store_ctl.wr_en = req_accept && (req_command == CMD_LOAD);
      store_ctl.rd_en = issue;
   end

   bfgr_store #(
      .Depth (FONT_STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_addr (AW'(req_font_address)),
      .wr_data (req_font_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_byte_offset_ff <= off_ff;
            rsp_row_bits_ff <= 16'(bits_cat);
            rsp_row_number_ff <= ROW_NUM_W'(row_ff);
            rsp_last_row_ff <= last_row;
            rsp_cursor_x_after_ff <= x_after_ff;
            rsp_cursor_y_after_ff <= cursor_y_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_command == CMD_SET_CURSOR)) begin
                  cursor_x_ff <= req_new_cursor_x;
                  cursor_y_ff <= req_new_cursor_y;
               end else if (req_accept && (req_command == CMD_DRAW)) begin
                  if (req_char_code == CODE_CR) begin
                     cursor_x_ff <= '0;
                  end else if (req_char_code == CODE_LF) begin
                     cursor_x_ff <= '0;
                     cursor_y_ff <= cursor_y_ff + 16'(h_eff);
                  end else begin
                     glyph_ff <= ({2'b0, req_char_code} < glyph_count_ff)
                                 ? {2'b0, req_char_code} : '0;
                     x_after_ff <= cursor_x_ff + 16'(w_eff) + 16'd1;
                     state_ff <= ST_MUL_Y;
                  end
               end
            end
            ST_MUL_Y: begin
               prod_ff <= mul_p;
               state_ff <= ST_MUL_G;
            end
            ST_MUL_G: begin
               off_ff <= prod_ff + {14'b0, cursor_x_ff, 2'b0};
               prod_ff <= mul_p;
               state_ff <= ST_ADDR;
            end
            ST_ADDR: begin
               addr_ff <= prod_ff[AW-1:0];
               iss_row_ff <= '0;
               iss_k_ff <= '0;
               row_ff <= '0;
               pend_ff <= 1'b0;
               if (h_eff == '0) begin
                  cursor_x_ff <= x_after_ff;
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               if (!hold) begin
                  if (pend_ff) begin
                     joined_ff <= joined_cat;
                  end
                  pend_ff <= issue;
                  pend_first_ff <= (iss_k_ff == '0);
                  pend_last_ff <= last_k;
                  if (issue) begin
                     addr_ff <= addr_ff + AW'(1);
                     if (last_k) begin
                        iss_k_ff <= '0;
                        iss_row_ff <= iss_row_ff + HW'(1);
                     end else begin
                        iss_k_ff <= iss_k_ff + KW'(1);
                     end
                  end
                  if (emit) begin
                     row_ff <= row_ff + HW'(1);
                     off_ff <= off_ff + {16'b0, line_pitch_ff};
                     if (last_row) begin
                        cursor_x_ff <= x_after_ff;
                        state_ff <= ST_IDLE;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || is_draw_pending();

   function automatic logic is_draw_pending();
      return 1'b0;
   endfunction

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte_offset = rsp_byte_offset_ff;
   assign rsp_row_bits = rsp_row_bits_ff;
   assign rsp_row_number = rsp_row_number_ff;
   assign rsp_last_row = rsp_last_row_ff;
   assign rsp_cursor_x_after = rsp_cursor_x_after_ff;
   assign rsp_cursor_y_after = rsp_cursor_y_after_ff;

   logic unused_is_draw;
   assign unused_is_draw = is_draw;

endmodule

`default_nettype wire

// ----- sv/bfgr_store.sv -----
// ----------------------------------------------------------------------------
// Glyph store
// Byte-wide font memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfgr_store
   import bfgr_pkg::*;
#(
   parameter int Depth = DEF_FONT_STORE_BYTES,
   localparam int AddrW = $clog2(Depth)
) (
   input  wire logic             clock,
   input  wire store_ctl_type    ctl,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [7:0]       wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [7:0]       rd_data
);

   logic [7:0] mem [Depth];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/bfgr_checker.sv -----
// ----------------------------------------------------------------------------
// Bitmap font glyph renderer checker
// Port-level properties of the renderer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_font_glyph_renderer_top_defines.svh"

module bfgr_checker
   import bfgr_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_command,
   input wire logic [7:0]  req_char_code,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_last_row,
   input wire logic [31:0] rsp_byte_offset
);

   // A waiting result stays offered and unchanged.
   `BFGR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `BFGR_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_byte_offset))

   // While a glyph is only partly delivered, no new transfer is taken.
   `BFGR_ASSERT_SAME(a_busy_mid_glyph, rsp_valid && !rsp_last_row, req_stall)

   // A printable character always starts the multiply sequence.
   `BFGR_ASSERT_NEXT(a_draw_busy,
      req_valid && !req_stall && (req_command == CMD_DRAW)
      && (req_char_code != CODE_CR) && (req_char_code != CODE_LF),
      req_stall)

endmodule

bind bitmap_font_glyph_renderer_top bfgr_checker u_bfgr_checker (.*);

`default_nettype wire
